>>> hdl/scsa_pkg.sv
package scsa_pkg;

    // Default geometry: twelve classes, 256 KB chunks, 8-byte smallest entry
    localparam int SCSA_NUM_CLASSES     = 12;
    localparam int SCSA_CHUNK_SHIFT     = 18;
    localparam int SCSA_MIN_ENTRY_SHIFT = 3;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int SIZE_W   = 16;
    localparam int ADDR_W   = 22;
    localparam int STATUS_W = 2;
    localparam int COPY_W   = 15;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REALLOC = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_LARGE = 2'd1,
        STATUS_NO_SLOT   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_POP,
        S_FREE,
        S_DONE
    } seq_state_t;

    // Offset of a class's links in the shared table: sum of the slot counts
    // of all lower classes. Elaboration-time only.
    function automatic int scsa_class_base(int c, int sw);
        int acc;
        acc = 0;
        for (int k = 0; k < c; k++)
        begin
            acc += (k < sw) ? (1 << (sw - k)) : 1;
        end
        return acc;
    endfunction

endpackage

>>> hdl/scsa_link_ram.sv
module scsa_link_ram #(
    parameter int AW = 16,
    parameter int DW = 15
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] link_mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            link_mem[waddr] <= wdata;
        end
        rd_data_reg <= link_mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

>>> hdl/scsa_index_unit.sv
module scsa_index_unit #(
    parameter int NUM_CLASSES     = scsa_pkg::SCSA_NUM_CLASSES,
    parameter int CHUNK_SHIFT     = scsa_pkg::SCSA_CHUNK_SHIFT,
    parameter int MIN_ENTRY_SHIFT = scsa_pkg::SCSA_MIN_ENTRY_SHIFT,
    parameter int CW              = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
    parameter int SW              = CHUNK_SHIFT - MIN_ENTRY_SHIFT,
    parameter int LW              = SW + 1
) (
    input  logic [CW-1:0] cls,
    input  logic [SW-1:0] slot,
    output logic [LW-1:0] idx
);
    import scsa_pkg::*;

    logic [LW-1:0] base_tbl [2**CW];

    // Constant per-class base offsets; codes past the last class read zero
    for (genvar g = 0; g < 2**CW; g++)
    begin : g_base
        if (g < NUM_CLASSES)
        begin : g_real
            assign base_tbl[g] = LW'(scsa_class_base(g, SW));
        end
        else
        begin : g_pad
            assign base_tbl[g] = '0;
        end
    end

    // Shared adder: wraps at the table depth
    assign idx = base_tbl[cls] + LW'(slot);

endmodule

>>> hdl/size_class_slab_allocator.sv
// done pulses in the done state: entered from decode for a failed, null, header-slot
// or in-place request, from pop for alloc, from free for free, from pop then free for
// a moving realloc (pop alone when the old address is a header slot, which is not
// pushed back). One request at a time: busy stays high until the state is idle.
// The link table has a registered read and one shared address, and one shared index
// adder serves every access. Reset: heads load slot 1 and empty bits clear at once,
// then an init pass fills the link table with busy high, one link per cycle.
module size_class_slab_allocator #(
    parameter int NUM_CLASSES     = scsa_pkg::SCSA_NUM_CLASSES,
    parameter int CHUNK_SHIFT     = scsa_pkg::SCSA_CHUNK_SHIFT,
    parameter int MIN_ENTRY_SHIFT = scsa_pkg::SCSA_MIN_ENTRY_SHIFT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [scsa_pkg::KIND_W-1:0]    kind,
    input  logic [scsa_pkg::SIZE_W-1:0]    req_size,
    input  logic [scsa_pkg::ADDR_W-1:0]    address,
    output logic                           done,
    output logic [scsa_pkg::ADDR_W-1:0]    result_address,
    output logic [scsa_pkg::STATUS_W-1:0]  status,
    output logic                           moved,
    output logic [scsa_pkg::COPY_W-1:0]    copy_bytes
);
    import scsa_pkg::*;

    localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SW = CHUNK_SHIFT - MIN_ENTRY_SHIFT;
    localparam int LW = SW + 1;
    localparam logic [31:0] CHUNK_MASK = (32'd1 << CHUNK_SHIFT) - 32'd1;

    seq_state_t state_reg, state_next;

    logic [KIND_W-1:0] kind_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic [SW-1:0] head_reg  [NUM_CLASSES];
    logic          empty_reg [NUM_CLASSES];

    logic [CW-1:0] init_cls_reg;
    logic [SW-1:0] init_slot_reg;

    logic [ADDR_W-1:0] res_addr_reg;
    status_t           status_reg;
    logic              moved_reg;
    logic [COPY_W-1:0] copy_reg;
    logic              move_pend_reg;
    logic              free_pend_reg;

    // Decode of the latched request
    logic [3:0]        msb;
    logic [4:0]        sc_full;
    logic              sc_big;
    logic [CW-1:0]     sc;
    logic [ADDR_W-1:0] ac_full;
    logic              ac_ok;
    logic [CW-1:0]     ac;
    logic [4:0]        es_old;
    logic [4:0]        es_new;
    logic              grow;
    logic [COPY_W-1:0] copy_val;
    logic [SW-1:0]     old_slot;
    logic              want_alloc;
    logic              move_next;
    logic [31:0]       compose;

    logic [CW-1:0] cur_cls;
    logic [SW-1:0] head_cur;
    logic          empty_cur;

    logic          init_has;
    logic [SW-1:0] init_last;
    logic          init_class_end;
    logic          init_done;

    logic [CW-1:0] unit_cls;
    logic [SW-1:0] unit_slot;
    logic [LW-1:0] unit_idx;
    logic          ram_we;
    logic [SW-1:0] ram_wdata;
    logic [SW-1:0] ram_rdata;

    always_comb
    begin
        msb = '0;
        for (int i = 1; i < SIZE_W; i++)
        begin
            if (size_reg[i])
            begin
                msb = 4'(i);
            end
        end
        sc_full  = (int'(msb) < MIN_ENTRY_SHIFT) ? 5'd0
                 : 5'(msb) - 5'(MIN_ENTRY_SHIFT) + 5'd1;
        sc_big   = int'(sc_full) >= NUM_CLASSES;
        sc       = sc_big ? '0 : CW'(sc_full);
        ac_full  = addr_reg >> CHUNK_SHIFT;
        ac_ok    = (addr_reg != '0) && (int'(ac_full) < NUM_CLASSES);
        ac       = ac_ok ? CW'(ac_full) : '0;
        es_old   = 5'(MIN_ENTRY_SHIFT) + 5'(ac);
        es_new   = 5'(MIN_ENTRY_SHIFT) + 5'(sc);
        grow     = 32'(size_reg) > (32'd1 << es_old);
        copy_val = COPY_W'(32'd1 << es_old);
        old_slot = SW'(((32'(addr_reg)) & CHUNK_MASK) >> es_old);

        want_alloc = (kind_reg == KIND_ALLOC)
                   || ((kind_reg == KIND_REALLOC) && (!ac_ok || grow));
        move_next  = (kind_reg == KIND_REALLOC) && ac_ok && grow;
    end

    // One head read port: the old class while freeing, the size class otherwise
    assign cur_cls   = (state_reg == S_FREE) ? ac : sc;
    assign head_cur  = (int'(cur_cls) < NUM_CLASSES) ? head_reg[cur_cls] : '0;
    assign empty_cur = (int'(cur_cls) < NUM_CLASSES) ? empty_reg[cur_cls] : 1'b1;
    assign compose   = (32'(sc) << CHUNK_SHIFT) | (32'(head_cur) << es_new);

    assign init_has       = int'(init_cls_reg) < SW;
    assign init_last      = {SW{1'b1}} >> init_cls_reg;
    assign init_class_end = !init_has || (init_slot_reg == init_last);
    assign init_done      = (int'(init_cls_reg) == NUM_CLASSES - 1) && init_class_end;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (init_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (want_alloc)
                begin
                    state_next = (sc_big || empty_cur) ? S_DONE : S_POP;
                end
                else if ((kind_reg == KIND_FREE) && ac_ok && (old_slot != '0))
                begin
                    state_next = S_FREE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP:    state_next = free_pend_reg ? S_FREE : S_DONE;
            S_FREE:   state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs and shared-unit steering
    always_comb
    begin
        busy      = (state_reg != S_IDLE);
        done      = (state_reg == S_DONE);
        unit_cls  = cur_cls;
        unit_slot = (state_reg == S_FREE) ? old_slot : head_cur;
        ram_we    = 1'b0;
        ram_wdata = empty_cur ? '0 : head_cur;
        case (state_reg)
            S_INIT:
            begin
                unit_cls  = init_cls_reg;
                unit_slot = init_slot_reg;
                ram_we    = init_has;
                ram_wdata = (init_slot_reg == init_last) ? '0 : init_slot_reg + SW'(1);
            end
            S_FREE:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign result_address = res_addr_reg;
    assign status         = status_reg;
    assign moved          = moved_reg;
    assign copy_bytes     = copy_reg;

    scsa_index_unit #(
        .NUM_CLASSES     (NUM_CLASSES),
        .CHUNK_SHIFT     (CHUNK_SHIFT),
        .MIN_ENTRY_SHIFT (MIN_ENTRY_SHIFT),
        .CW              (CW),
        .SW              (SW),
        .LW              (LW)
    ) u_index (
        .cls  (unit_cls),
        .slot (unit_slot),
        .idx  (unit_idx)
    );

    scsa_link_ram #(
        .AW (LW),
        .DW (SW)
    ) u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (unit_idx),
        .wdata (ram_wdata),
        .raddr (unit_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_cls_reg  <= '0;
            init_slot_reg <= SW'(1);
            move_pend_reg <= 1'b0;
            free_pend_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c]  <= (c < SW) ? SW'(1) : '0;
                empty_reg[c] <= (c >= SW);
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_INIT:
                begin
                    // Advance through each class's slots, then to the next class
                    if (init_class_end)
                    begin
                        init_cls_reg  <= init_cls_reg + CW'(1);
                        init_slot_reg <= SW'(1);
                    end
                    else
                    begin
                        init_slot_reg <= init_slot_reg + SW'(1);
                    end
                end
                S_DECODE:
                begin
                    move_pend_reg <= want_alloc && move_next;
                    free_pend_reg <= want_alloc && move_next && (old_slot != '0);
                end
                S_POP:
                begin
                    head_reg[sc] <= ram_rdata;
                    if (ram_rdata == '0)
                    begin
                        empty_reg[sc] <= 1'b1;
                    end
                end
                S_FREE:
                begin
                    head_reg[ac]  <= old_slot;
                    empty_reg[ac] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_reg <= kind;
                    size_reg <= req_size;
                    addr_reg <= address;
                end
            end
            S_DECODE:
            begin
                res_addr_reg <= '0;
                status_reg   <= STATUS_OK;
                moved_reg    <= 1'b0;
                copy_reg     <= '0;
                if (want_alloc)
                begin
                    if (sc_big)
                    begin
                        status_reg <= STATUS_TOO_LARGE;
                    end
                    else if (empty_cur)
                    begin
                        status_reg <= STATUS_NO_SLOT;
                    end
                end
                else if (kind_reg == KIND_REALLOC)
                begin
                    // Fits in place: hand the address back
                    res_addr_reg <= addr_reg;
                end
            end
            S_POP:
            begin
                res_addr_reg <= compose[ADDR_W-1:0];
                if (move_pend_reg)
                begin
                    moved_reg <= 1'b1;
                    copy_reg  <= copy_val;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("request transfer did not start a sequence");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> ((result_address == '0) && !moved))
        else $error("failed request returned an address or a move");

    a_move_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && moved) |-> (status == STATUS_OK))
        else $error("move reported with a failure status");

endmodule

>>> tb/tb_size_class_slab_allocator.sv
module tb_size_class_slab_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import scsa_pkg::*;

    localparam int NCLS       = SCSA_NUM_CLASSES;
    localparam int CSH        = SCSA_CHUNK_SHIFT;
    localparam int ESH        = SCSA_MIN_ENTRY_SHIFT;
    localparam int HEAD_W     = CSH - ESH;
    localparam int LINK_W     = CSH - ESH + 1;
    localparam int LINKS      = 1 << LINK_W;
    localparam int CHUNK_MASK = (1 << CSH) - 1;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_OPS    = 1780;
    localparam int DRAIN_EVERY   = 300;
    localparam int BURST_SPAN    = 64;
    localparam int MAX_GAP       = 14;
    localparam int SETTLE_CYCLES = 8;
    // covers the link table init pass after reset with room to spare
    localparam int IDLE_LIMIT    = 200000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           st;
        logic              moved;
        logic [COPY_W-1:0] copy;
    } slab_reply_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        slab_reply_t       want;
    } directed_row_t;

    localparam int DIRECTED_N = 23;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{KIND_ALLOC,   16'd0,     22'h000000, 1'b1, '{22'h000008, STATUS_OK, 1'b0, 15'd0}},
        '{KIND_ALLOC,   16'd7,     22'h3FFFFF, 1'b1, '{22'h000010, STATUS_OK, 1'b0, 15'd0}},
        '{KIND_ALLOC,   16'd16383, 22'h000000, 1'b1, '{22'h2C4000, STATUS_OK, 1'b0, 15'd0}},
        '{KIND_ALLOC,   16'd16384, 22'h000000, 1'b1,
          '{22'h000000, STATUS_TOO_LARGE, 1'b0, 15'd0}},
        '{KIND_ALLOC,   16'hFFFF,  22'h000000, 1'b1,
          '{22'h000000, STATUS_TOO_LARGE, 1'b0, 15'd0}},
        '{KIND_FREE,    16'd0,     22'h000000, 1'b1, '0},
        '{KIND_FREE,    16'hFFFF,  22'h3FFFFF, 1'b1, '0},
        // header slot of the top class
        '{KIND_FREE,    16'd0,     22'h2C0000, 1'b1, '0},
        '{KIND_UNUSED,  16'hFFFF,  22'h3FFFFF, 1'b1, '0},
        '{KIND_REALLOC, 16'd8,     22'h000008, 1'b1, '{22'h000008, STATUS_OK, 1'b0, 15'd0}},
        '{KIND_REALLOC, 16'd9,     22'h000008, 1'b0, '0},
        '{KIND_REALLOC, 16'd20000, 22'h040010, 1'b1,
          '{22'h000000, STATUS_TOO_LARGE, 1'b0, 15'd0}},
        '{KIND_REALLOC, 16'd16,    22'h000000, 1'b0, '0},
        '{KIND_REALLOC, 16'd0,     22'h300000, 1'b0, '0},
        // unaligned free, then the same slot again
        '{KIND_FREE,    16'd0,     22'h040013, 1'b1, '0},
        '{KIND_FREE,    16'd0,     22'h040013, 1'b1, '0},
        '{KIND_ALLOC,   16'd9,     22'h000000, 1'b0, '0},
        '{KIND_ALLOC,   16'd9,     22'h000000, 1'b0, '0},
        '{KIND_FREE,    16'd0,     22'h2C4000, 1'b1, '0},
        '{KIND_ALLOC,   16'd8192,  22'h000000, 1'b0, '0},
        '{KIND_REALLOC, 16'd16383, 22'h2C4000, 1'b1, '{22'h2C4000, STATUS_OK, 1'b0, 15'd0}},
        '{KIND_ALLOC,   16'd4096,  22'h000000, 1'b0, '0},
        '{KIND_REALLOC, 16'd16000, 22'h282000, 1'b0, '0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [KIND_W-1:0]   kind;
    logic [SIZE_W-1:0]   req_size;
    logic [ADDR_W-1:0]   address;
    logic                done;
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;
    logic                moved;
    logic [COPY_W-1:0]   copy_bytes;

    size_class_slab_allocator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .req_size       (req_size),
        .address        (address),
        .done           (done),
        .result_address (result_address),
        .status         (status),
        .moved          (moved),
        .copy_bytes     (copy_bytes)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // free-list mirror
    logic [HEAD_W-1:0] head_slot [NCLS];
    bit                list_empty [NCLS];
    logic [LINK_W-1:0] slot_link [LINKS];
    int unsigned       link_base [NCLS];

    slab_reply_t       slab_reply_q [$];
    logic [ADDR_W-1:0] live_slots [$];

    int fault_count = 0;
    int op_count = 0;
    int move_count = 0;
    int no_slot_count = 0;
    int oversize_count = 0;
    int idle_cycles = 0;

    task automatic clear_free_lists();
        int unsigned base;
        int unsigned n;
        base = 0;
        foreach (slot_link[i])
            slot_link[i] = '0;
        for (int c = 0; c < NCLS; c++)
        begin
            n = (ESH + c >= CSH) ? 1 : (1 << (CSH - ESH - c));
            link_base[c] = base;
            if (n >= 2)
            begin
                head_slot[c] = 1;
                list_empty[c] = 1'b0;
                for (int unsigned i = 1; i + 1 < n; i++)
                    slot_link[(base + i) & (LINKS - 1)] = LINK_W'(i + 1);
                slot_link[(base + n - 1) & (LINKS - 1)] = '0;
            end
            else
            begin
                head_slot[c] = '0;
                list_empty[c] = 1'b1;
            end
            base += n;
        end
    endtask

    function automatic int size_class(input logic [SIZE_W-1:0] sz);
        int b;
        int c;
        b = 0;
        for (int i = 0; i < SIZE_W; i++)
            if (sz[i])
                b = i;
        c = (b < ESH) ? 0 : b - ESH + 1;
        return (c < NCLS) ? c : NCLS;
    endfunction

    function automatic status_t pop_slot(input logic [SIZE_W-1:0] sz,
                                         output logic [ADDR_W-1:0] got);
        int c;
        int unsigned slot;
        logic [LINK_W-1:0] nxt;
        c = size_class(sz);
        got = '0;
        if (c >= NCLS)
            return STATUS_TOO_LARGE;
        if (list_empty[c])
            return STATUS_NO_SLOT;
        slot = head_slot[c];
        nxt = slot_link[(link_base[c] + slot) & (LINKS - 1)];
        if (nxt == '0)
        begin
            list_empty[c] = 1'b1;
            head_slot[c] = '0;
        end
        else
            head_slot[c] = nxt[HEAD_W-1:0];
        got = ADDR_W'((c << CSH) | (slot << (ESH + c)));
        return STATUS_OK;
    endfunction

    function automatic void push_slot(input int c, input logic [ADDR_W-1:0] a);
        int unsigned slot;
        slot = (int'(a) & CHUNK_MASK) >> (ESH + c);
        if (slot == 0)
            return;
        slot_link[(link_base[c] + slot) & (LINKS - 1)] =
            list_empty[c] ? '0 : LINK_W'(head_slot[c]);
        head_slot[c] = HEAD_W'(slot);
        list_empty[c] = 1'b0;
    endfunction

    function automatic slab_reply_t slab_step(input logic [KIND_W-1:0] k,
                                              input logic [SIZE_W-1:0] sz,
                                              input logic [ADDR_W-1:0] a);
        slab_reply_t r;
        int c;
        int unsigned ent;
        logic [ADDR_W-1:0] got;
        status_t st;
        r = '0;
        c = int'(a) >> CSH;
        case (k)
            KIND_ALLOC:
            begin
                r.st = pop_slot(sz, got);
                r.addr = got;
            end
            KIND_FREE:
            begin
                if (a != '0 && c < NCLS)
                    push_slot(c, a);
            end
            KIND_REALLOC:
            begin
                if (a == '0 || c >= NCLS)
                begin
                    r.st = pop_slot(sz, got);
                    r.addr = got;
                end
                else
                begin
                    ent = 1 << (ESH + c);
                    if (sz > ent)
                    begin
                        st = pop_slot(sz, got);
                        r.st = st;
                        r.addr = got;
                        // keep the old slot when the move fails
                        if (st == STATUS_OK)
                        begin
                            push_slot(c, a);
                            r.moved = 1'b1;
                            r.copy = COPY_W'(ent);
                        end
                    end
                    else
                        r.addr = a;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int c;
        case ($urandom_range(0, 19))
            0: return SIZE_W'($urandom);
            1: return SIZE_W'($urandom_range(1 << (ESH + NCLS - 1), (1 << SIZE_W) - 1));
            default:
            begin
                // lean on the top classes so they run dry
                c = ($urandom_range(0, 1) == 0) ? $urandom_range(NCLS - 2, NCLS - 1)
                                                : $urandom_range(0, NCLS - 1);
                if (c == 0)
                    return SIZE_W'($urandom_range(0, (1 << ESH) - 1));
                return SIZE_W'($urandom_range(1 << (ESH + c - 1), (1 << (ESH + c)) - 1));
            end
        endcase
    endfunction

    function automatic int next_gap(input bit no_gaps);
        return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic issue(input logic [KIND_W-1:0] k, input logic [SIZE_W-1:0] sz,
                         input logic [ADDR_W-1:0] a, input int gap,
                         input bit use_want, input slab_reply_t want,
                         output slab_reply_t got);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        kind     <= k;
        req_size <= sz;
        address  <= a;
        do
            @(posedge clk);
        while (busy);
        got = slab_step(k, sz, a);
        slab_reply_q.push_back(use_want ? want : got);
        op_count++;
        if (got.moved)
            move_count++;
        if (got.st == STATUS_NO_SLOT)
            no_slot_count++;
        if (got.st == STATUS_TOO_LARGE)
            oversize_count++;
    endtask

    // hold off the sender until every reply is back
    task automatic wait_for_replies();
        start <= 1'b0;
        do
            @(posedge clk);
        while (slab_reply_q.size() != 0);
    endtask

    initial
    begin
        int choice;
        int idx;
        bit from_pool;
        bit no_gaps;
        logic [KIND_W-1:0] k;
        logic [SIZE_W-1:0] sz;
        logic [ADDR_W-1:0] a;
        slab_reply_t got;

        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_ALLOC;
        req_size = '0;
        address = '0;
        no_gaps = 1'b0;
        clear_free_lists();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            issue(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].size, DIRECTED_ROWS[i].addr,
                  next_gap(1'b0), DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want, got);
        wait_for_replies();

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % BURST_SPAN == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                wait_for_replies();
            choice = $urandom_range(0, 99);
            from_pool = 1'b0;
            idx = 0;
            k = KIND_ALLOC;
            sz = pick_size();
            a = ADDR_W'($urandom);
            if (choice < 35)
            begin
                k = KIND_ALLOC;
            end
            else if (choice < 78 && live_slots.size() > 0)
            begin
                idx = $urandom_range(0, live_slots.size() - 1);
                a = live_slots[idx];
                from_pool = 1'b1;
                if (choice < 60)
                begin
                    k = KIND_FREE;
                    live_slots.delete(idx);
                    // stray offset bits inside the slot
                    if ($urandom_range(0, 3) == 0)
                        a = a | (ADDR_W'($urandom) &
                                 ADDR_W'((1 << (ESH + (int'(a) >> CSH))) - 1));
                end
                else
                    k = KIND_REALLOC;
            end
            else if (choice < 86)
            begin
                k = KIND_REALLOC;
                if ($urandom_range(0, 1) == 0)
                    a = '0;
                else
                    a = ADDR_W'(($urandom_range(NCLS, (1 << (ADDR_W - CSH)) - 1) << CSH) |
                                ($urandom & CHUNK_MASK));
            end
            else if (choice < 96)
            begin
                k = KIND_FREE;
                case ($urandom_range(0, 3))
                    0: a = '0;
                    1: a = ADDR_W'($urandom_range(0, NCLS - 1) << CSH);
                    default: a = ADDR_W'($urandom);
                endcase
            end
            else
            begin
                k = KIND_UNUSED;
                sz = SIZE_W'($urandom);
            end

            issue(k, sz, a, next_gap(no_gaps), 1'b0, '0, got);

            if (k == KIND_REALLOC && from_pool && got.moved)
                live_slots.delete(idx);
            if (got.st == STATUS_OK &&
                (k == KIND_ALLOC || got.moved || (k == KIND_REALLOC && !from_pool)))
                live_slots.push_back(got.addr);
        end

        start <= 1'b0;
        do
            @(posedge clk);
        while (slab_reply_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d operations (alloc, free, realloc, unused kind)", op_count);
        $display("  %0d moving reallocs, %0d out-of-slot failures, %0d oversize requests",
                 move_count, no_slot_count, oversize_count);
        if (fault_count == 0)
            $display("size_class_slab_allocator: match");
        else
            $display("size_class_slab_allocator: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        slab_reply_t want;
        if (rst_n && done)
        begin
            if (slab_reply_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("%0t: unexpected transfer addr=%h status=%0d moved=%0d copy=%0d",
                             $realtime, result_address, status, moved, copy_bytes);
            end
            else
            begin
                want = slab_reply_q.pop_front();
                if (result_address !== want.addr || status !== want.st ||
                    moved !== want.moved || copy_bytes !== want.copy)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                    begin
                        $display("%0t: expected addr=%h status=%0d moved=%0d copy=%0d",
                                 $realtime, want.addr, want.st, want.moved, want.copy);
                        $display("%0t:   actual addr=%h status=%0d moved=%0d copy=%0d",
                                 $realtime, result_address, status, moved, copy_bytes);
                    end
                end
            end
        end
    end

    // count cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no transfer for %0d cycles", IDLE_LIMIT);
            $display("size_class_slab_allocator: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
